// File: rtl/core/rbi_pkg.sv
// Shared constants and types of the ray versus box intersection block.
package rbi_pkg;

  // Default coordinate format: signed Q16.16 in 32 bits
  localparam int unsigned CoordBitsDef  = 32;
  localparam int unsigned FracBitsDef   = 16;
  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  // Per-item classification from the front
  typedef struct packed {
    logic       enclosed; // origin strictly inside the box
    logic [2:0] face_ok;  // face of this axis is to be tested
    logic [2:0] ovf;      // quotient of this axis saturates
  } cls_t;

endpackage

// File: rtl/core/rbi_if.sv
// Channel interfaces of the ray versus box intersection block.
interface rbi_in_if #(
  parameter int unsigned COORD_BITS = rbi_pkg::CoordBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_min_z;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] box_max_z;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic signed [COORD_BITS-1:0] direction_x;
  logic signed [COORD_BITS-1:0] direction_y;
  logic signed [COORD_BITS-1:0] direction_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    output ready
  );
endinterface

interface rbi_out_if #(
  parameter int unsigned COORD_BITS = rbi_pkg::CoordBitsDef
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [COORD_BITS-2:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

// File: rtl/core/rbi_front.sv
// Front end: accepts a beat, classifies the origin and sets up the face divisions.
module rbi_front #(
  parameter int unsigned COORD_BITS = rbi_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = rbi_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rbi_in_if.sink                     in_i,
  output logic                       item_valid_o,
  input  logic                       item_ready_i,
  output rbi_pkg::cls_t              cls_o,
  output logic [18*COORD_BITS-1:0]   data_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned WD = 2 * C + FRAC_BITS;

  typedef struct packed {
    logic [C-1:0] num;
    logic [C-1:0] den;
    logic [C-1:0] org;
    logic [C-1:0] dir;
    logic [C-1:0] lo;
    logic [C-1:0] hi;
  } ax_t;

  logic signed [C-1:0] lo   [3];
  logic signed [C-1:0] hi   [3];
  logic signed [C-1:0] org  [3];
  logic signed [C-1:0] dir  [3];

  ax_t [2:0]      ax_d, ax_q;
  rbi_pkg::cls_t  cls_d, cls_q;
  logic           vld_q;

  assign lo[0]  = in_i.box_min_x;
  assign lo[1]  = in_i.box_min_y;
  assign lo[2]  = in_i.box_min_z;
  assign hi[0]  = in_i.box_max_x;
  assign hi[1]  = in_i.box_max_y;
  assign hi[2]  = in_i.box_max_z;
  assign org[0] = in_i.origin_x;
  assign org[1] = in_i.origin_y;
  assign org[2] = in_i.origin_z;
  assign dir[0] = in_i.direction_x;
  assign dir[1] = in_i.direction_y;
  assign dir[2] = in_i.direction_z;

  // Classify each axis: at most one face of an axis is a candidate
  always_comb begin
    logic              lo_side, hi_side;
    logic signed [C:0] diff_lo, diff_hi;
    logic [WD-1:0]     num_ext, den_ext;
    cls_d.enclosed = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo_side = (org[a] < lo[a]) && (dir[a] > 0);
      hi_side = (org[a] > hi[a]) && dir[a][C-1];
      diff_lo = (C+1)'(lo[a]) - (C+1)'(org[a]);
      diff_hi = (C+1)'(org[a]) - (C+1)'(hi[a]);
      ax_d[a].num = lo_side ? diff_lo[C-1:0] : diff_hi[C-1:0];
      ax_d[a].den = lo_side ? dir[a] : C'(~dir[a] + 1'b1);
      ax_d[a].org = org[a];
      ax_d[a].dir = dir[a];
      ax_d[a].lo  = lo[a];
      ax_d[a].hi  = hi[a];
      // quotient saturates when num * 2^F >= den * 2^(C-1)
      num_ext = WD'(ax_d[a].num) << FRAC_BITS;
      den_ext = WD'(ax_d[a].den) << (C - 1);
      cls_d.face_ok[a] = lo_side | hi_side;
      cls_d.ovf[a]     = num_ext >= den_ext;
      cls_d.enclosed   = cls_d.enclosed && (org[a] > lo[a]) && (org[a] < hi[a]);
    end
  end

  assign in_i.ready = !vld_q || item_ready_i;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ax_q  <= ax_d;
      cls_q <= cls_d;
    end
  end

  assign item_valid_o = vld_q;
  assign cls_o        = cls_q;
  assign data_o       = ax_q;

endmodule

// File: rtl/core/rbi_queue.sv
// Short FIFO that decouples the front end from the back end.
module rbi_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rbi_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CntW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/rbi_back.sv
// Back end: pipelined face divisions, hit-point checks and nearest-hit selection.
module rbi_back #(
  parameter int unsigned COORD_BITS = rbi_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = rbi_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  rbi_pkg::cls_t            cls_i,
  input  logic [18*COORD_BITS-1:0] data_i,
  rbi_out_if.source                out_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned QB  = C - 1;          // quotient bits
  localparam int unsigned WD  = 2 * C + F;      // remainder width
  localparam int unsigned TL  = QB / 2;         // low split of t
  localparam int unsigned TH  = QB - TL;
  localparam int unsigned PW  = C + QB;         // full product width
  localparam int unsigned VW  = (PW > C + 2) ? PW : C + 2;
  localparam int unsigned SW  = C + 3;          // scaled offset, signed
  localparam int unsigned HW  = C + 4;          // hit point, signed

  typedef struct packed {
    logic [C-1:0] num;
    logic [C-1:0] den;
    logic [C-1:0] org;
    logic [C-1:0] dir;
    logic [C-1:0] lo;
    logic [C-1:0] hi;
  } ax_t;

  typedef struct packed {
    logic                 enclosed;
    logic [2:0]           face_ok;
    logic [2:0]           ovf;
    logic [2:0][WD-1:0]   rem;
    logic [2:0][C-1:0]    den;
    logic [2:0][C-1:0]    org;
    logic [2:0][C-1:0]    dir;
    logic [2:0][C-1:0]    lo;
    logic [2:0][C-1:0]    hi;
    logic [2:0][QB-1:0]   quo;
  } div_t;

  typedef struct packed {
    logic                       enclosed;
    logic [2:0]                 tok;
    logic [2:0][QB-1:0]         t;
    logic [2:0][1:0][C+TL-1:0]  pl;
    logic [2:0][1:0][C+TH-1:0]  ph;
    logic [2:0][1:0]            neg;
    logic [2:0][1:0][C-1:0]     org;
    logic [2:0][1:0][C-1:0]     lo;
    logic [2:0][1:0][C-1:0]     hi;
  } m1_t;

  typedef struct packed {
    logic                    enclosed;
    logic [2:0]              tok;
    logic [2:0][QB-1:0]      t;
    logic [2:0][1:0][PW-1:0] prod;
    logic [2:0][1:0]         neg;
    logic [2:0][1:0][C-1:0]  org;
    logic [2:0][1:0][C-1:0]  lo;
    logic [2:0][1:0][C-1:0]  hi;
  } m2_t;

  typedef struct packed {
    logic                    enclosed;
    logic [2:0]              tok;
    logic [2:0][QB-1:0]      t;
    logic [2:0][1:0][SW-1:0] sv;
    logic [2:0][1:0][C-1:0]  org;
    logic [2:0][1:0][C-1:0]  lo;
    logic [2:0][1:0][C-1:0]  hi;
  } m3_t;

  typedef struct packed {
    logic               enclosed;
    logic [2:0]         hit;
    logic [2:0][QB-1:0] t;
  } m4_t;

  ax_t [2:0]    ax_in;
  div_t         div_init;
  div_t         div_q [QB+1];
  logic [QB:0]  dvld_q;
  m1_t          m1_d, m1_q;
  m2_t          m2_d, m2_q;
  m3_t          m3_d, m3_q;
  m4_t          m4_d, m4_q;
  logic [3:0]   mvld_q;
  logic         en;
  logic         out_vld_q, hit_q, hit_d;
  logic [QB-1:0] dist_q, dist_d;

  // Whole pipeline advances unless the output beat is stuck
  assign en           = !out_vld_q || out_o.ready;
  assign item_ready_o = en;
  assign ax_in        = data_i;

  // Division set-up: remainder starts at num * 2^F
  always_comb begin
    div_init.enclosed = cls_i.enclosed;
    div_init.face_ok  = cls_i.face_ok;
    div_init.ovf      = cls_i.ovf;
    for (int a = 0; a < 3; a++) begin
      div_init.rem[a] = WD'(ax_in[a].num) << F;
      div_init.den[a] = ax_in[a].den;
      div_init.org[a] = ax_in[a].org;
      div_init.dir[a] = ax_in[a].dir;
      div_init.lo[a]  = ax_in[a].lo;
      div_init.hi[a]  = ax_in[a].hi;
      div_init.quo[a] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= div_init;
    end
  end

  // Restoring division, one quotient bit per stage on all three lanes
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int unsigned K = QB - 1 - s;
    div_t nxt;
    always_comb begin
      logic [WD-1:0] sub;
      nxt = div_q[s];
      for (int a = 0; a < 3; a++) begin
        sub = WD'(div_q[s].den[a]) << K;
        if (div_q[s].rem[a] >= sub) begin
          nxt.rem[a]    = div_q[s].rem[a] - sub;
          nxt.quo[a][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[s+1] <= nxt;
      end
    end
  end

  // Saturate t, then partial products of |d| * t on the two other axes
  always_comb begin
    logic [QB-1:0] t;
    logic [C-1:0]  mag;
    int            j;
    m1_d.enclosed = div_q[QB].enclosed;
    for (int i = 0; i < 3; i++) begin
      t = div_q[QB].ovf[i] ? '1 : div_q[QB].quo[i];
      m1_d.t[i]   = t;
      m1_d.tok[i] = div_q[QB].face_ok[i] && (t != '0);
      for (int jj = 0; jj < 2; jj++) begin
        j   = (i + 1 + jj) % 3;
        mag = div_q[QB].dir[j][C-1] ? C'(~div_q[QB].dir[j] + 1'b1) : div_q[QB].dir[j];
        m1_d.pl[i][jj]  = (C+TL)'(mag) * (C+TL)'(t[TL-1:0]);
        m1_d.ph[i][jj]  = (C+TH)'(mag) * (C+TH)'(t[QB-1:TL]);
        m1_d.neg[i][jj] = div_q[QB].dir[j][C-1];
        m1_d.org[i][jj] = div_q[QB].org[j];
        m1_d.lo[i][jj]  = div_q[QB].lo[j];
        m1_d.hi[i][jj]  = div_q[QB].hi[j];
      end
    end
  end

  // Sum of partial products
  always_comb begin
    m2_d.enclosed = m1_q.enclosed;
    m2_d.tok      = m1_q.tok;
    m2_d.t        = m1_q.t;
    m2_d.neg      = m1_q.neg;
    m2_d.org      = m1_q.org;
    m2_d.lo       = m1_q.lo;
    m2_d.hi       = m1_q.hi;
    for (int i = 0; i < 3; i++) begin
      for (int jj = 0; jj < 2; jj++) begin
        m2_d.prod[i][jj] = PW'(m1_q.pl[i][jj]) + (PW'(m1_q.ph[i][jj]) << TL);
      end
    end
  end

  // Scale down with floor rounding, clamp, apply sign
  always_comb begin
    logic [VW-1:0]  vv;
    logic [C+1:0]   mag2;
    logic           remnz;
    m3_d.enclosed = m2_q.enclosed;
    m3_d.tok      = m2_q.tok;
    m3_d.t        = m2_q.t;
    m3_d.org      = m2_q.org;
    m3_d.lo       = m2_q.lo;
    m3_d.hi       = m2_q.hi;
    for (int i = 0; i < 3; i++) begin
      for (int jj = 0; jj < 2; jj++) begin
        remnz = |(m2_q.prod[i][jj] & ((PW'(1) << F) - PW'(1)));
        vv    = VW'(m2_q.prod[i][jj] >> F);
        if (vv > (VW'(1) << (C + 1))) begin
          vv = VW'(1) << (C + 1);
        end
        mag2 = vv[C+1:0] + (C+2)'(remnz && m2_q.neg[i][jj]);
        m3_d.sv[i][jj] = m2_q.neg[i][jj] ? SW'(~SW'(mag2) + 1'b1) : SW'(mag2);
      end
    end
  end

  // Hit point against the box on the two other axes
  always_comb begin
    logic signed [HW-1:0] p;
    logic                 in_box;
    m4_d.enclosed = m3_q.enclosed;
    m4_d.t        = m3_q.t;
    for (int i = 0; i < 3; i++) begin
      in_box = 1'b1;
      for (int jj = 0; jj < 2; jj++) begin
        p = HW'($signed(m3_q.org[i][jj])) + HW'($signed(m3_q.sv[i][jj]));
        in_box = in_box && (p >= HW'($signed(m3_q.lo[i][jj])))
                        && (p <= HW'($signed(m3_q.hi[i][jj])));
      end
      m4_d.hit[i] = m3_q.tok[i] && in_box;
    end
  end

  // Nearest hit among the three lanes; an enclosed origin gives a hit at distance zero
  always_comb begin
    hit_d  = 1'b0;
    dist_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (m4_q.hit[i] && (!hit_d || m4_q.t[i] < dist_d)) begin
        hit_d  = 1'b1;
        dist_d = m4_q.t[i];
      end
    end
    if (m4_q.enclosed) begin
      hit_d  = 1'b1;
      dist_d = '0;
    end
  end

  // Stage valids and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q    <= '0;
      mvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      dvld_q    <= {dvld_q[QB-1:0], item_valid_i};
      mvld_q    <= {mvld_q[2:0], dvld_q[QB]};
      out_vld_q <= mvld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      m3_q   <= m3_d;
      m4_q   <= m4_d;
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.hit      = hit_q;
  assign out_o.distance = dist_q;

endmodule

// File: rtl/core/ray_box_intersect_top.sv
// Ray versus axis-aligned box intersection test, top level.
// Throughput: one beat per cycle while the output side accepts results; the
// face divisions run as a pipelined restoring divider, one quotient bit per
// stage, COORD_BITS-1 stages. A beat passes the front register, the queue, the
// divider set-up and stages, two product stages, scaling, check and select.
// Reset clears only the valid flags, queue pointers and fill count; no clearing pass.
module ray_box_intersect_top #(
  parameter int unsigned COORD_BITS  = rbi_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS   = rbi_pkg::FracBitsDef,
  parameter int unsigned QUEUE_DEPTH = rbi_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbi_in_if.sink    in_i,
  rbi_out_if.source out_o
);

  localparam int unsigned DataW = 18 * COORD_BITS;
  localparam int unsigned QW    = $bits(rbi_pkg::cls_t) + DataW;

  logic                f_valid, f_ready, q_valid, q_ready;
  rbi_pkg::cls_t       f_cls, q_cls;
  logic [DataW-1:0]    f_data, q_data;

  rbi_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .cls_o        (f_cls),
    .data_o       (f_data)
  );

  rbi_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_cls, f_data}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   ({q_cls, q_data})
  );

  rbi_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .cls_i        (q_cls),
    .data_i       (q_data),
    .out_o
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench of the ray versus axis-aligned box intersection block.
module testbench;

  localparam int CB = rbi_pkg::CoordBitsDef;
  localparam int FB = rbi_pkg::FracBitsDef;
  localparam int LATENCY = CB + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint TMAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint PLIM = 64'sd1 <<< (CB + 1);

  typedef struct packed {
    logic signed [CB-1:0] bmin_x, bmin_y, bmin_z;
    logic signed [CB-1:0] bmax_x, bmax_y, bmax_z;
    logic signed [CB-1:0] org_x, org_y, org_z;
    logic signed [CB-1:0] dir_x, dir_y, dir_z;
  } ray_box_t;

  typedef struct packed {
    logic          hit;
    logic [CB-2:0] distance;
  } hit_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rbi_in_if  #(.COORD_BITS(CB)) in_ch();
  rbi_out_if #(.COORD_BITS(CB)) out_ch();

  ray_box_intersect_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #10 clk_i = ~clk_i;

  hit_result_t expected_hits[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          stall_free = 1'b0;
  bit          timed_out = 1'b0;

  // Intersection predictor: returns hit flag and nearest t
  function automatic hit_result_t predict_hit(ray_box_t it);
    longint      lo[3], hi[3], o[3], d[3];
    longint      num, den, t, q, r, p, m, v, best;
    logic [127:0] prod;
    bit          hit, ok, neg;
    hit_result_t res;
    lo[0] = it.bmin_x; lo[1] = it.bmin_y; lo[2] = it.bmin_z;
    hi[0] = it.bmax_x; hi[1] = it.bmax_y; hi[2] = it.bmax_z;
    o[0]  = it.org_x;  o[1]  = it.org_y;  o[2]  = it.org_z;
    d[0]  = it.dir_x;  d[1]  = it.dir_y;  d[2]  = it.dir_z;
    hit = 1'b0;
    best = 0;
    if (o[0] > lo[0] && o[0] < hi[0] && o[1] > lo[1] && o[1] < hi[1] &&
        o[2] > lo[2] && o[2] < hi[2]) begin
      res.hit = 1'b1;
      res.distance = '0;
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      for (int side = 0; side < 2; side++) begin
        if (side == 0) begin
          if (!(o[i] < lo[i] && d[i] > 0)) continue;
          num = lo[i] - o[i];
          den = d[i];
        end else begin
          if (!(o[i] > hi[i] && d[i] < 0)) continue;
          num = o[i] - hi[i];
          den = -d[i];
        end
        // exact quotient with FB fraction bits, saturated
        q = num / den;
        r = num % den;
        if (q > (TMAX >>> FB)) t = TMAX;
        else t = ((q <<< FB) | ((r <<< FB) / den));
        if (t == 0) continue;
        ok = 1'b1;
        for (int j = 0; j < 3; j++) begin
          if (j == i) continue;
          neg = d[j] < 0;
          m = neg ? -d[j] : d[j];
          prod = 128'(m) * 128'(t);
          v = (prod >> FB) > 128'(PLIM) ? PLIM : longint'(prod >> FB);
          if (neg) v = -(v + ((prod[FB-1:0] != 0) ? 1 : 0));
          p = o[j] + v;
          if (p < lo[j] || p > hi[j]) ok = 1'b0;
        end
        if (ok && (!hit || t < best)) begin
          hit = 1'b1;
          best = t;
        end
      end
    end
    res.hit = hit;
    res.distance = hit ? best[CB-2:0] : '0;
    return res;
  endfunction

  function automatic bit idle_roll();
    return !stall_free && ($urandom_range(99) < 6);
  endfunction

  // Result side ready, changed at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= !idle_roll();
  end

  // Send one ray/box beat and queue its prediction
  task automatic send_ray(ray_box_t it);
    while (idle_roll()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.box_min_x   <= it.bmin_x; in_ch.box_min_y <= it.bmin_y;
    in_ch.box_min_z   <= it.bmin_z;
    in_ch.box_max_x   <= it.bmax_x; in_ch.box_max_y <= it.bmax_y;
    in_ch.box_max_z   <= it.bmax_z;
    in_ch.origin_x    <= it.org_x;  in_ch.origin_y  <= it.org_y;
    in_ch.origin_z    <= it.org_z;
    in_ch.direction_x <= it.dir_x;  in_ch.direction_y <= it.dir_y;
    in_ch.direction_z <= it.dir_z;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_hits.push_back(predict_hit(it));
    @(negedge clk_i);
  endtask

  // Result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    hit_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat hit=%0b", out_ch.hit);
      end else begin
        want = expected_hits.pop_front();
        if (want.hit !== out_ch.hit || want.distance !== out_ch.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
                     want.hit, want.distance, out_ch.hit, out_ch.distance);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat while results are pending or a beat is offered
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        expected_hits.size() == 0 && !in_ch.valid)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      timed_out <= 1'b1;
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(5))
      0: return CB'({$urandom, $urandom});
      1: return $signed(CB'(1) <<< (CB - 1));
      2: return {1'b0, {(CB-1){1'b1}}};
      default: return CB'($signed($urandom_range(2000)) - 1000) <<< FB;
    endcase
  endfunction

  // Random box with a ray aimed roughly at it
  function automatic ray_box_t aimed_ray();
    ray_box_t it;
    int c[3], h[3], org[3], dir[3];
    for (int k = 0; k < 3; k++) begin
      c[k] = $urandom_range(400) - 200;
      h[k] = $urandom_range(50, 1);
      org[k] = $urandom_range(800) - 400;
      dir[k] = c[k] - org[k] + $urandom_range(40) - 20;
    end
    it.bmin_x = (c[0] - h[0]) <<< FB; it.bmax_x = (c[0] + h[0]) <<< FB;
    it.bmin_y = (c[1] - h[1]) <<< FB; it.bmax_y = (c[1] + h[1]) <<< FB;
    it.bmin_z = (c[2] - h[2]) <<< FB; it.bmax_z = (c[2] + h[2]) <<< FB;
    it.org_x = (org[0] <<< FB) + $urandom_range(65535);
    it.org_y = (org[1] <<< FB) + $urandom_range(65535);
    it.org_z = (org[2] <<< FB) + $urandom_range(65535);
    it.dir_x = dir[0] * $urandom_range(4096, 1);
    it.dir_y = dir[1] * $urandom_range(4096, 1);
    it.dir_z = dir[2] * $urandom_range(4096, 1);
    if ($urandom_range(9) == 0) it.dir_y = 0;
    return it;
  endfunction

  function automatic ray_box_t unit_box(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_box_t it;
    it.bmin_x = -(1 <<< FB); it.bmin_y = -(1 <<< FB); it.bmin_z = -(1 <<< FB);
    it.bmax_x = 1 <<< FB;    it.bmax_y = 1 <<< FB;    it.bmax_z = 1 <<< FB;
    it.org_x = ox <<< FB; it.org_y = oy <<< FB; it.org_z = oz <<< FB;
    it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
    return it;
  endfunction

  // Drop valid and hold until every expected result has come or the watchdog fires
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_hits.size() != 0 && !timed_out) @(negedge clk_i);
  endtask

  // Directed: inside, each face, zero direction, on plane, edges, saturation
  task automatic test_directed();
    ray_box_t it;
    send_ray(unit_box(0, 0, 0, 0, 0, 0));
    send_ray(unit_box(-5, 0, 0, 1 <<< FB, 0, 0));
    send_ray(unit_box(5, 0, 0, -(1 <<< FB), 0, 0));
    send_ray(unit_box(0, -5, 0, 0, 1 <<< FB, 0));
    send_ray(unit_box(0, 5, 0, 0, -(1 <<< FB), 0));
    send_ray(unit_box(0, 0, -5, 0, 0, 1 <<< FB));
    send_ray(unit_box(0, 0, 5, 0, 0, -(1 <<< FB)));
    send_ray(unit_box(-5, 0, 0, -(1 <<< FB), 0, 0));
    send_ray(unit_box(1, 0, 0, -(1 <<< FB), 0, 0));
    send_ray(unit_box(-5, -3, 0, 1 <<< FB, 1 <<< FB, 0));
    send_ray(unit_box(-5, 5, 5, 1 <<< FB, -(1 <<< FB), -(1 <<< FB)));
    send_ray(unit_box(-5, 0, 0, 1, 0, 0));
    send_ray(unit_box(-5, 0, 0, 32'h7fffffff, 32'h80000000, 0));
    send_ray(unit_box(-5, 4, 0, 1 <<< FB, 0, 0));
    it = unit_box(0, 0, 0, 0, 0, 0);
    it.bmin_x = 32'sh80000000; it.bmax_x = 32'sh7fffffff;
    it.org_y = 32'sh80000000; it.dir_y = 32'sh7fffffff;
    send_ray(it);
    it.bmin_x = 5 <<< FB; it.bmax_x = -(5 <<< FB);
    send_ray(it);
    it = unit_box(0, 0, 0, 0, 0, 0);
    {it.org_x, it.org_y, it.org_z} = '1;
    {it.dir_x, it.dir_y, it.dir_z} = '1;
    send_ray(it);
    send_ray(ray_box_t'('0));
    send_ray(ray_box_t'('1));
  endtask

  // Random: mostly aimed rays, some raw noise
  task automatic test_random(int count);
    ray_box_t it;
    for (int n = 0; n < count && !timed_out; n++) begin
      stall_free = (n >= count / 2) && (n < count / 2 + 100);
      if ($urandom_range(3) == 0) begin
        it = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      end else it = aimed_ray();
      send_ray(it);
      if (n == count / 4) wait_drained();
    end
    stall_free = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z} = '0;
    {in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z} = '0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    {in_ch.direction_x, in_ch.direction_y, in_ch.direction_z} = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(680);
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (timed_out) begin
      $display("testbench failed");
    end else if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rbi_pkg.sv
rtl/core/rbi_if.sv
rtl/core/rbi_front.sv
rtl/core/rbi_queue.sv
rtl/core/rbi_back.sv
rtl/core/ray_box_intersect_top.sv
bench/testbench.sv
